@@ rtl/core/sorted_coordinate_set_table_defines.svh @@
// Assertion macros shared by the sorted coordinate set table RTL.
// No dependencies; define SYNTH to compile the checks away.
`ifndef SORTED_COORDINATE_SET_TABLE_DEFINES_SVH
`define SORTED_COORDINATE_SET_TABLE_DEFINES_SVH

`ifndef SYNTH
// Antecedent holds in this cycle -> consequent holds in the same cycle
`define SCST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("scst assertion failed");
// Antecedent holds in this cycle -> consequent holds in the next cycle
`define SCST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("scst assertion failed");
`else
`define SCST_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SCST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/core/scst_pkg.sv @@
// Types and constants for the sorted coordinate set table.
// No dependencies; used by scst_cell and sorted_coordinate_set_table.
package scst_pkg;

  // Table depth and the count that fits in entry_count
  localparam int CAPACITY = 32;
  localparam int USABLE   = (CAPACITY < 63) ? CAPACITY : 63;
  localparam int CNT_W    = $clog2(USABLE + 1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_DUMP   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FOUND     = 3'd5,
    ST_ENTRY     = 3'd6,
    ST_EMPTY     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_DUMP
  } fsm_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  pos_x;
    logic [9:0]  pos_y;
    logic [7:0]  tag;
  } in_req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_tag;
    logic [7:0]  out_x;
    logic [9:0]  out_y;
    logic [5:0]  entry_count;
    logic        last;
  } out_res_t;

  // Sort key: row first, then column
  typedef logic [17:0] key_t;

  typedef struct packed {
    logic        valid;
    logic [9:0]  y;
    logic [7:0]  x;
    logic [7:0]  tag;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;   // open a gap at the insertion point and fill it
    logic del;   // close the gap at the matching cell
    logic rot;   // rotate the valid entries left by one
  } cell_ctl_t;

endpackage

@@ rtl/core/sorted_coordinate_set_table.sv @@
// Sorted coordinate set table, top level. A request is taken when in_valid
// and in_ready are high; in_ready is high only while no request is in work.
// Insert, remove and lookup are registered with the request and finish in the EXEC
// state once the output register is free: the whole chain of CAPACITY slot cells
// compares its entries with the key in parallel and shifts by one place there.
// A dump emits one held entry per cycle in the DUMP state while the output is
// free, as the chain rotates one entry to the head; an empty dump just returns EMPTY.
// Results wait in an output register, and a stalled out_ready holds the work.
// Depends on scst_pkg, scst_cell and sorted_coordinate_set_table_defines.svh.
`include "sorted_coordinate_set_table_defines.svh"

module sorted_coordinate_set_table import scst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_res
);

  fsm_t             state_r, state_nxt;
  in_req_t          req_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_res_t         out_r, out_nxt;

  cell_ctl_t        ctl;
  key_t             key;
  entry_t           new_ent;
  entry_t           cell_ent [CAPACITY];
  logic [CAPACITY-1:0] lt_vec, eq_vec;
  logic             hit, full, out_free;
  logic [7:0]       hit_tag;

  assign key     = {req_r.pos_y, req_r.pos_x};
  assign new_ent = '{valid: 1'b1, y: req_r.pos_y, x: req_r.pos_x, tag: req_r.tag};

  // Chain of slot cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_l;
    if (g == 0) begin : g_head
      assign left_e = new_ent;
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_e = cell_ent[g-1];
      assign left_l = lt_vec[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cell_ent[g+1];
    end
    scst_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .key       (key),
      .new_ent   (new_ent),
      .left_ent  (left_e),
      .left_lt   (left_l),
      .right_ent (right_e),
      .head_ent  (cell_ent[0]),
      .ent       (cell_ent[g]),
      .lt        (lt_vec[g]),
      .eq        (eq_vec[g])
    );
  end

  // Match summary: at most one cell matches, so OR-ing tags selects it
  always_comb begin
    hit_tag = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_tag = hit_tag | (eq_vec[i] ? cell_ent[i].tag : 8'd0);
    end
  end
  assign hit      = |eq_vec;
  assign full     = (count_r >= CNT_W'(USABLE));
  assign out_free = !out_valid_r || out_ready;

  assign in_ready  = (state_r == FSM_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // Sequencer: next state, cell commands and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    ctl           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_valid) begin
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (out_free) begin
          out_nxt.out_tag = 8'd0;
          out_nxt.out_x   = req_r.pos_x;
          out_nxt.out_y   = req_r.pos_y;
          out_nxt.last    = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = FSM_IDLE;
          unique case (req_r.action)
            ACT_INSERT: begin
              if (hit) begin
                out_nxt.status = ST_DUPLICATE;
              end else if (full) begin
                out_nxt.status = ST_FULL;
              end else begin
                ctl.ins        = 1'b1;
                count_nxt      = count_r + 1'b1;
                out_nxt.status = ST_INSERTED;
              end
            end
            ACT_REMOVE: begin
              if (hit) begin
                ctl.del        = 1'b1;
                count_nxt      = count_r - 1'b1;
                out_nxt.status = ST_REMOVED;
              end else begin
                out_nxt.status = ST_NOT_FOUND;
              end
            end
            ACT_LOOKUP: begin
              if (hit) begin
                out_nxt.status  = ST_FOUND;
                out_nxt.out_tag = hit_tag;
              end else begin
                out_nxt.status = ST_NOT_FOUND;
              end
            end
            ACT_DUMP: begin
              if (count_r == '0) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = out_valid_r && !out_ready;
                out_nxt       = out_r;
                rem_nxt       = count_r;
                state_nxt     = FSM_DUMP;
              end
            end
            default: begin
              out_nxt.status = ST_NOT_FOUND;
            end
          endcase
          out_nxt.entry_count = 6'(count_nxt);
        end
      end
      FSM_DUMP: begin
        // emit the head entry, then rotate the chain by one
        if (out_free) begin
          out_nxt.status      = ST_ENTRY;
          out_nxt.out_tag     = cell_ent[0].tag;
          out_nxt.out_x       = cell_ent[0].x;
          out_nxt.out_y       = cell_ent[0].y;
          out_nxt.entry_count = 6'(count_r);
          out_nxt.last        = (rem_r == CNT_W'(1));
          out_valid_nxt       = 1'b1;
          ctl.rot             = 1'b1;
          rem_nxt             = rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = FSM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
    out_r <= out_nxt;
  end

  // Valid cells must form a prefix as long as the count
  logic [CAPACITY-1:0] valid_vec, exp_valid;
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_vec[i] = cell_ent[i].valid;
      exp_valid[i] = (CNT_W'(i) < count_r);
    end
  end

  `SCST_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(USABLE))
  `SCST_ASSERT_IMP(a_valid_prefix, clk, rst_n, state_r != FSM_EXEC, valid_vec == exp_valid)
  `SCST_ASSERT_IMP(a_dump_nonempty, clk, rst_n, state_r == FSM_DUMP, count_r != '0)
  `SCST_ASSERT_NEXT(a_nonlast_from_dump, clk, rst_n, out_valid_r && !out_r.last && out_ready,
                    out_valid_r || state_r == FSM_DUMP)

endmodule

@@ rtl/core/scst_cell.sv @@
// One slot of the sorted chain: holds an entry, compares it with the key.
// Depends on scst_pkg.
module scst_cell import scst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  key_t      key,
  input  entry_t    new_ent,
  input  entry_t    left_ent,
  input  logic      left_lt,
  input  entry_t    right_ent,
  input  entry_t    head_ent,
  output entry_t    ent,
  output logic      lt,
  output logic      eq
);

  logic       valid_r, valid_nxt;
  entry_t     data_r, data_nxt;
  key_t       own_key;

  // Compare held entry against the broadcast key
  assign own_key = {data_r.y, data_r.x};
  assign lt      = valid_r && (own_key < key);
  assign eq      = valid_r && (own_key == key);

  assign ent = '{valid: valid_r, y: data_r.y, x: data_r.x, tag: data_r.tag};

  // Next contents from self or a neighbor
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctl.ins && !lt) begin
      // first cell at or above the key takes the new point, the rest shift up
      data_nxt  = left_lt ? new_ent : left_ent;
      valid_nxt = data_nxt.valid;
    end else if (ctl.del && !lt) begin
      data_nxt  = right_ent;
      valid_nxt = right_ent.valid;
    end else if (ctl.rot && valid_r) begin
      // last valid cell wraps around to the head entry
      data_nxt  = right_ent.valid ? right_ent : head_ent;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

@@ dv/sorted_coordinate_set_table_test.sv @@
// Self-checking testbench for sorted_coordinate_set_table: a shadow table predicts
// every result of insert, remove, lookup and dump. Depends on scst_pkg and the RTL.
`timescale 1ns / 1ps

module sorted_coordinate_set_table_test;
  import scst_pkg::*;

  localparam int STALL_LIMIT = 4000;

  // Shadow of the point table plus the queue of results still due
  class point_table_shadow;
    typedef struct packed {
      logic [9:0] y;
      logic [7:0] x;
      logic [7:0] tag;
    } point_t;

    point_t      points[$];       // ascending by row, then column
    out_res_t    due_results[$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned per_action[4];
    int unsigned peak;
    int unsigned full_hits;
    int unsigned longest_dump;

    function automatic out_res_t make_res(status_t st, logic [7:0] tg, logic [7:0] x,
                                          logic [9:0] y, logic last);
      out_res_t r;
      r.status      = st;
      r.out_tag     = tg;
      r.out_x       = x;
      r.out_y       = y;
      r.entry_count = 6'(points.size());
      r.last        = last;
      return r;
    endfunction

    // Apply one accepted request and queue the results it must produce
    function automatic void note_request(in_req_t rq);
      logic [17:0] want;
      int          idx;
      bit          hit;
      status_t     st;
      logic [7:0]  tg;
      point_t      p;
      per_action[int'(rq.action)]++;
      if (rq.action == ACT_DUMP) begin
        if (points.size() == 0) begin
          due_results.push_back(make_res(ST_EMPTY, 8'h00, rq.pos_x, rq.pos_y, 1'b1));
        end else begin
          foreach (points[i])
            due_results.push_back(make_res(ST_ENTRY, points[i].tag, points[i].x,
                                           points[i].y, i == points.size() - 1));
          if (points.size() > longest_dump) longest_dump = points.size();
        end
        return;
      end
      want = {rq.pos_y, rq.pos_x};
      idx  = 0;
      while (idx < points.size() && {points[idx].y, points[idx].x} < want) idx++;
      hit = (idx < points.size()) && ({points[idx].y, points[idx].x} == want);
      tg  = 8'h00;
      case (rq.action)
        ACT_INSERT: begin
          if (hit) begin
            st = ST_DUPLICATE;
          end else if (points.size() >= USABLE) begin
            st = ST_FULL;
            full_hits++;
          end else begin
            p.x   = rq.pos_x;
            p.y   = rq.pos_y;
            p.tag = rq.tag;
            points.insert(idx, p);
            st = ST_INSERTED;
            if (points.size() > peak) peak = points.size();
          end
        end
        ACT_REMOVE: begin
          if (hit) begin
            points.delete(idx);
            st = ST_REMOVED;
          end else begin
            st = ST_NOT_FOUND;
          end
        end
        default: begin
          if (hit) begin
            st = ST_FOUND;
            tg = points[idx].tag;
          end else begin
            st = ST_NOT_FOUND;
          end
        end
      endcase
      due_results.push_back(make_res(st, tg, rq.pos_x, rq.pos_y, 1'b1));
    endfunction

    // Compare one accepted result against the oldest one due
    function automatic void check_result(out_res_t got);
      out_res_t want;
      string    diffs;
      results_seen++;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result: status=%0d tag=%02h x=%0d y=%0d count=%0d last=%0b",
                   $time, got.status, got.out_tag, got.out_x, got.out_y, got.entry_count,
                   got.last);
        return;
      end
      want  = due_results.pop_front();
      diffs = "";
      if (got.status !== want.status)           diffs = {diffs, " status"};
      if (got.out_tag !== want.out_tag)         diffs = {diffs, " out_tag"};
      if (got.out_x !== want.out_x)             diffs = {diffs, " out_x"};
      if (got.out_y !== want.out_y)             diffs = {diffs, " out_y"};
      if (got.entry_count !== want.entry_count) diffs = {diffs, " entry_count"};
      if (got.last !== want.last)               diffs = {diffs, " last"};
      if (diffs == "") return;
      errors++;
      if (errors <= 10) begin
        $display("[%0t] result %0d differs in%s", $time, results_seen, diffs);
        $display("  expected status=%0d tag=%02h x=%0d y=%0d count=%0d last=%0b",
                 want.status, want.out_tag, want.out_x, want.out_y, want.entry_count,
                 want.last);
        $display("  actual   status=%0d tag=%02h x=%0d y=%0d count=%0d last=%0b",
                 got.status, got.out_tag, got.out_x, got.out_y, got.entry_count, got.last);
      end
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_res;

  bit                steady;      // both sides skip idling while set
  int unsigned       idle_cycles;
  point_table_shadow shadow = new();

  sorted_coordinate_set_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  always #6 clk = ~clk;

  // Watchdog: too long without any handshake means the block is stuck
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Result side: random stall before each result, then check it
  initial begin : result_sink
    int unsigned hold;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 16);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      shadow.check_result(out_res);
    end
  end

  // Present one request after a random gap and hold it until taken
  task automatic send_request(in_req_t rq);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= rq;
    do @(posedge clk); while (!in_ready);
    shadow.note_request(rq);
  endtask

  task automatic send_fields(action_t act, int x, int y, int tg);
    in_req_t rq;
    rq.action = act;
    rq.pos_x  = 8'(x);
    rq.pos_y  = 10'(y);
    rq.tag    = 8'(tg);
    send_request(rq);
  endtask

  // Hold the input side off until every due result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (shadow.due_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic action_t pick_action(int unsigned w_ins, int unsigned w_rem,
                                          int unsigned w_look);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < w_ins) return ACT_INSERT;
    if (r < w_ins + w_rem) return ACT_REMOVE;
    if (r < w_ins + w_rem + w_look) return ACT_LOOKUP;
    return ACT_DUMP;
  endfunction

  // Coordinates: a held point, a tight cluster, a corner, or anywhere
  function automatic in_req_t make_req(action_t act, int unsigned hit_pct);
    in_req_t     rq;
    int unsigned pick;
    int unsigned idx;
    rq.action = act;
    rq.tag    = 8'($urandom_range(0, 255));
    rq.pos_x  = 8'($urandom_range(0, 255));
    rq.pos_y  = 10'($urandom_range(0, 1023));
    pick      = $urandom_range(0, 99);
    if (pick < hit_pct && shadow.points.size() != 0) begin
      idx      = $urandom_range(0, shadow.points.size() - 1);
      rq.pos_x = shadow.points[idx].x;
      rq.pos_y = shadow.points[idx].y;
    end else if (pick < hit_pct + (100 - hit_pct) / 3) begin
      rq.pos_x = 8'($urandom_range(0, 3));
      rq.pos_y = 10'($urandom_range(0, 3));
    end else if (pick >= 92) begin
      rq.pos_x = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      rq.pos_y = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
    end
    return rq;
  endfunction

  // idle_mode: 0 random idling, 1 none, 2 alternating stretches of 16
  task automatic run_phase(int unsigned count, int unsigned w_ins, int unsigned w_rem,
                           int unsigned w_look, int unsigned hit_pct, int unsigned idle_mode);
    for (int unsigned n = 0; n < count; n++) begin
      steady = (idle_mode == 1) || (idle_mode == 2 && ((n / 16) % 2 == 1));
      send_request(make_req(pick_action(w_ins, w_rem, w_look), hit_pct));
    end
    steady = 1'b0;
  endtask

  initial begin
    steady = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, corners, same-row ordering, misses and duplicates
    send_fields(ACT_DUMP,     9,    4,    0);
    send_fields(ACT_LOOKUP,   5,    7,    0);
    send_fields(ACT_REMOVE,   0,    0,    0);
    send_fields(ACT_INSERT,   0,    0,    8'h00);
    send_fields(ACT_INSERT,   255,  1023, 8'hFF);
    send_fields(ACT_INSERT,   7,    3,    8'hA5);
    send_fields(ACT_INSERT,   3,    7,    8'h5A);
    send_fields(ACT_INSERT,   8,    3,    8'h3C);
    send_fields(ACT_INSERT,   7,    3,    8'h11);
    send_fields(ACT_LOOKUP,   7,    3,    8'hEE);
    send_fields(ACT_LOOKUP,   8,    4,    0);
    send_fields(ACT_DUMP,     0,    0,    0);
    send_fields(ACT_REMOVE,   255,  1023, 0);
    send_fields(ACT_REMOVE,   255,  1023, 0);
    send_fields(ACT_LOOKUP,   0,    0,    0);
    send_fields(ACT_INSERT,   255,  0,    8'hFF);
    send_fields(ACT_INSERT,   0,    1023, 8'h80);
    send_fields(ACT_DUMP,     255,  1023, 8'hFF);
    send_fields(ACT_REMOVE,   0,    0,    0);
    send_fields(ACT_REMOVE,   7,    3,    0);
    send_fields(ACT_LOOKUP,   3,    7,    0);
    send_fields(ACT_DUMP,     1,    2,    0);

    // Fill until inserts bounce off a full table
    run_phase(90, 85, 3, 6, 15, 0);
    drain_results();
    // Churn near capacity with no idling
    run_phase(90, 35, 30, 25, 50, 1);
    // Mostly removals, emptying the table again
    run_phase(70, 15, 60, 15, 60, 0);
    drain_results();
    // Even mix with alternating idle and busy stretches
    run_phase(70, 25, 25, 25, 30, 2);

    drain_results();
    repeat (40) @(posedge clk);

    $display("Covered %0d inserts, %0d removes, %0d lookups, %0d dumps; %0d results checked.",
             shadow.per_action[0], shadow.per_action[1], shadow.per_action[2],
             shadow.per_action[3], shadow.results_seen);
    $display("Table peaked at %0d of %0d points, %0d inserts refused as full, longest dump %0d.",
             shadow.peak, USABLE, shadow.full_hits, shadow.longest_dump);
    if (shadow.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d result errors", shadow.errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
